// ===== src/nmec_pkg.sv =====
package nmec_pkg;

  // Fixed field widths
  localparam int unsigned SET_W     = 16;
  localparam int unsigned STATE_W   = 4;
  localparam int unsigned SYM_W     = 2;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned ACT_W     = 5;

  // Defaults for the top level parameters
  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  // Number of NFA states that carry meaning in a set or an entry
  localparam int unsigned STATE_COUNT = 16;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Symbol codes
  localparam logic [SYM_W-1:0] SYM_ZERO = 2'd0;
  localparam logic [SYM_W-1:0] SYM_ONE  = 2'd1;
  localparam logic [SYM_W-1:0] SYM_EPS  = 2'd2;

  // One transition table entry, as stored
  typedef struct packed {
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] to_state;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Bit k set where state k is below the state count
  function automatic logic [SET_W-1:0] state_mask_f();
    logic [SET_W-1:0] m;
    m = '0;
    for (int k = 0; k < SET_W; k++) begin
      m[k] = (k < STATE_COUNT);
    end
    return m;
  endfunction

  localparam logic [SET_W-1:0] STATE_MASK = state_mask_f();

endpackage

// ===== src/nmec_ram.sv =====
module nmec_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word with a registered output
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/nfa_move_epsilon_closure.sv =====
// NFA move and epsilon closure, one step of the subset construction.
//
// Input channel (in_valid_i / in_stall_o): a load word writes one slot of
// the transition table; a query word brings a state bitmap and a symbol.
// Output channel (out_valid_o / out_stall_i): one word per input word,
// either the closed state set of a query or a zero acknowledge of a load.
// cfg_we_i / cfg_data_i set the number of active table entries; write it
// only while the block is idle.
//
// A query walks the table in passes, one entry per cycle through the single
// read port of the table memory, using one shared match unit: a move pass
// for symbol 0 or 1, then closure passes until a pass adds no state; a
// query takes at most 17 passes.
// Only one word is in flight; in_stall_o is high while it is at work.
// The result sits in an output register; while out_stall_i holds it, the
// next word is still taken, but its result waits until the register frees.
// Reset clears the control state and the active entry count; the table
// contents stay undefined until loaded.
module nfa_move_epsilon_closure #(
  parameter int unsigned TABLE_ENTRIES = nmec_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [nmec_pkg::ACT_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [nmec_pkg::IDX_W-1:0]          entry_index_i,
  input  logic [nmec_pkg::STATE_W-1:0]        entry_from_i,
  input  logic [nmec_pkg::SYM_W-1:0]          entry_symbol_i,
  input  logic [nmec_pkg::STATE_W-1:0]        entry_to_i,
  input  logic [nmec_pkg::SET_W-1:0]          query_set_i,
  input  logic [nmec_pkg::SYM_W-1:0]          query_symbol_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [nmec_pkg::SET_W-1:0]          result_set_o,
  output logic                                was_query_o
);

  import nmec_pkg::*;

  localparam int unsigned IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned TCW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CW  = (TCW > ACT_W) ? TCW : ACT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_CLOSE,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [ACT_W-1:0] active_q;
  logic [SET_W-1:0] set_q;
  logic [SET_W-1:0] reached_q;
  logic [SYM_W-1:0] sym_q;
  logic             wq_q;
  logic [IW-1:0]    rd_idx_q;
  logic             issue_q;
  logic             vld_q;
  logic             vld_last_q;
  logic             changed_q;
  logic             out_valid_q;
  logic [SET_W-1:0] result_q;
  logic             was_query_q;

  logic             in_acc;
  logic             out_free;
  logic             out_load;
  logic [CW-1:0]    used_n;
  logic [IW-1:0]    last_idx;
  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic [SYM_W-1:0] match_sym;
  logic             hit;
  logic [SET_W-1:0] to_bit;
  logic [SET_W-1:0] reached_d;
  logic [SET_W-1:0] set_d;
  logic             changed_d;
  logic [SET_W-1:0] qset_masked;

  // Handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_DONE) && out_free;

  // Active entries, capped at the table depth
  always_comb begin
    logic [CW-1:0] act_ext;
    logic [CW-1:0] depth_c;
    act_ext  = CW'(active_q);
    depth_c  = CW'(TABLE_ENTRIES);
    used_n   = (act_ext > depth_c) ? depth_c : act_ext;
    last_idx = IW'(used_n - CW'(1));
  end

  // Table write on a load word
  assign ram_we    = in_acc && (command_i == CMD_LOAD) &&
                     (int'(entry_index_i) < TABLE_ENTRIES);
  assign ram_waddr = IW'(entry_index_i);
  assign ram_wdata = '{from_state: entry_from_i, symbol: entry_symbol_i,
                       to_state: entry_to_i};

  nmec_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue_q),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Shared match unit: one table entry against the current set
  assign match_sym = (state_q == ST_MOVE) ? sym_q : SYM_EPS;
  assign to_bit    = SET_W'(1) << ram_rdata.to_state;
  assign hit       = vld_q && (ram_rdata.symbol == match_sym) &&
                     set_q[ram_rdata.from_state] &&
                     STATE_MASK[ram_rdata.from_state] &&
                     STATE_MASK[ram_rdata.to_state];
  assign reached_d = hit ? (reached_q | to_bit) : reached_q;
  assign set_d     = hit ? (set_q | to_bit) : set_q;
  assign changed_d = changed_q || (hit && !set_q[ram_rdata.to_state]);
  assign qset_masked = query_set_i & STATE_MASK;

  // Sequencer, table walk and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      set_q       <= '0;
      reached_q   <= '0;
      sym_q       <= '0;
      wq_q        <= 1'b0;
      rd_idx_q    <= '0;
      issue_q     <= 1'b0;
      vld_q       <= 1'b0;
      vld_last_q  <= 1'b0;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
      result_q    <= '0;
      was_query_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_data_i;
      end

      // Load a finished result, or drop the output word once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
        result_q    <= set_q;
        was_query_q <= wq_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // Advance the read pointer while a pass issues reads
      vld_q      <= issue_q;
      vld_last_q <= issue_q && (rd_idx_q == last_idx);
      if (issue_q) begin
        if (rd_idx_q == last_idx) begin
          issue_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + IW'(1);
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (command_i == CMD_LOAD) begin
              set_q   <= '0;
              wq_q    <= 1'b0;
              state_q <= ST_DONE;
            end else begin
              wq_q      <= 1'b1;
              sym_q     <= query_symbol_i;
              reached_q <= '0;
              changed_q <= 1'b0;
              rd_idx_q  <= '0;
              if (used_n == '0) begin
                set_q   <= (query_symbol_i == SYM_ZERO || query_symbol_i == SYM_ONE)
                           ? '0 : qset_masked;
                state_q <= ST_DONE;
              end else begin
                set_q   <= qset_masked;
                issue_q <= 1'b1;
                state_q <= (query_symbol_i == SYM_ZERO || query_symbol_i == SYM_ONE)
                           ? ST_MOVE : ST_CLOSE;
              end
            end
          end
        end

        ST_MOVE: begin
          reached_q <= reached_d;
          if (vld_last_q) begin
            // Move done: close over the reached states
            set_q     <= reached_d;
            changed_q <= 1'b0;
            rd_idx_q  <= '0;
            issue_q   <= 1'b1;
            state_q   <= ST_CLOSE;
          end
        end

        ST_CLOSE: begin
          set_q     <= set_d;
          changed_q <= vld_last_q ? 1'b0 : changed_d;
          if (vld_last_q) begin
            if (changed_d) begin
              rd_idx_q <= '0;
              issue_q  <= 1'b1;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end

        ST_DONE: begin
          // Hold the result until the output register frees
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign result_set_o = result_q;
  assign was_query_o  = was_query_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import nmec_pkg::*;

  localparam int unsigned TBL_N = TABLE_ENTRIES_DEF;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned PHASE_WORDS = 250;

  // One input word as the driver sees it
  typedef struct {
    logic               cmd;
    logic [IDX_W-1:0]   slot;
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] to_state;
    logic [SET_W-1:0]   qset;
    logic [SYM_W-1:0]   qsym;
  } word_t;

  // One awaited output word
  typedef struct {
    logic [SET_W-1:0] set_bits;
    logic             was_query;
  } reply_t;

  // Keeps its own copy of the transition memory and the active count,
  // works out the closed set for each accepted word and checks replies.
  class closure_board;
    entry_t      trans_mem [TBL_N];
    int unsigned active_cnt;
    reply_t      pending_replies [$];
    int unsigned fault_count;

    function new();
      foreach (trans_mem[i]) trans_mem[i] = '0;
      active_cnt = 0;
      fault_count = 0;
    endfunction

    function void set_active(logic [ACT_W-1:0] v);
      active_cnt = v;
    endfunction

    // States reached from src in one step on sym
    function logic [SET_W-1:0] reach(logic [SET_W-1:0] src, logic [SYM_W-1:0] sym);
      logic [SET_W-1:0] hit;
      int unsigned used;
      hit = '0;
      used = (active_cnt > TBL_N) ? TBL_N : active_cnt;
      for (int i = 0; i < used; i++) begin
        if (trans_mem[i].symbol == sym && trans_mem[i].from_state < STATE_COUNT &&
            trans_mem[i].to_state < STATE_COUNT && src[trans_mem[i].from_state]) begin
          hit[trans_mem[i].to_state] = 1'b1;
        end
      end
      return hit;
    endfunction

    // Grow the set along epsilon edges until it stops changing
    function logic [SET_W-1:0] close_set(logic [SET_W-1:0] src);
      logic [SET_W-1:0] cur, prev;
      cur = src;
      do begin
        prev = cur;
        cur = cur | reach(cur, SYM_EPS);
      end while (cur != prev);
      return cur;
    endfunction

    function void note_word(word_t w);
      reply_t r;
      logic [SET_W-1:0] s;
      if (w.cmd == CMD_LOAD) begin
        if (w.slot < TBL_N) begin
          trans_mem[w.slot] = '{from_state: w.from_state, symbol: w.symbol,
                                to_state: w.to_state};
        end
        r.set_bits = '0;
        r.was_query = 1'b0;
      end else begin
        s = w.qset & STATE_MASK;
        if (w.qsym == SYM_ZERO || w.qsym == SYM_ONE) begin
          s = reach(s, w.qsym);
        end
        r.set_bits = close_set(s);
        r.was_query = 1'b1;
      end
      pending_replies = {pending_replies, r};
    endfunction

    function void check_word(logic [SET_W-1:0] got_set, logic got_query);
      reply_t want;
      if (pending_replies.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("unexpected word: set=%h was_query=%b", got_set, got_query);
        end
      end else begin
        want = pending_replies.pop_front();
        if (want.set_bits !== got_set || want.was_query !== got_query) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch: set exp=%h got=%h, was_query exp=%b got=%b",
                     want.set_bits, got_set, want.was_query, got_query);
          end
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [ACT_W-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               command_i = CMD_LOAD;
  logic [IDX_W-1:0]   entry_index_i = '0;
  logic [STATE_W-1:0] entry_from_i = '0;
  logic [SYM_W-1:0]   entry_symbol_i = SYM_ZERO;
  logic [STATE_W-1:0] entry_to_i = '0;
  logic [SET_W-1:0]   query_set_i = '0;
  logic [SYM_W-1:0]   query_symbol_i = SYM_ZERO;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [SET_W-1:0]   result_set_o;
  logic               was_query_o;

  closure_board board = new();
  bit           calm_run = 1'b0;
  int unsigned  cycle_count = 0;

  nfa_move_epsilon_closure #(
    .TABLE_ENTRIES(TBL_N)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .entry_index_i  (entry_index_i),
    .entry_from_i   (entry_from_i),
    .entry_symbol_i (entry_symbol_i),
    .entry_to_i     (entry_to_i),
    .query_set_i    (query_set_i),
    .query_symbol_i (query_symbol_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_set_o   (result_set_o),
    .was_query_o    (was_query_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Give up on a hung block
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Check the word taken at this edge, then pick the stall for the next one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_word(result_set_o, was_query_o);
    end
    out_stall_i <= !calm_run && ($urandom_range(0, 99) < 20);
  end

  function automatic word_t load_word(logic [IDX_W-1:0] slot, logic [STATE_W-1:0] f,
                                      logic [SYM_W-1:0] sym, logic [STATE_W-1:0] t);
    word_t w;
    w.cmd = CMD_LOAD;
    w.slot = slot;
    w.from_state = f;
    w.symbol = sym;
    w.to_state = t;
    w.qset = SET_W'($urandom_range(0, 65535));
    w.qsym = SYM_W'($urandom_range(0, 3));
    return w;
  endfunction

  function automatic word_t query_word(logic [SET_W-1:0] s, logic [SYM_W-1:0] sym);
    word_t w;
    w = load_word(IDX_W'($urandom_range(0, 15)), STATE_W'($urandom_range(0, 15)),
                  SYM_W'($urandom_range(0, 3)), STATE_W'($urandom_range(0, 15)));
    w.cmd = CMD_QUERY;
    w.qset = s;
    w.qsym = sym;
    return w;
  endfunction

  // Mostly queries over sparse or dense sets; loads favour epsilon chains
  function automatic word_t random_word();
    logic [STATE_W-1:0] f;
    logic [SYM_W-1:0]   sym;
    logic [STATE_W-1:0] t;
    logic [SET_W-1:0]   s;
    if ($urandom_range(0, 99) < 30) begin
      f = STATE_W'($urandom_range(0, 15));
      sym = ($urandom_range(0, 99) < 45) ? SYM_EPS : SYM_W'($urandom_range(0, 3));
      t = ($urandom_range(0, 99) < 30) ? f + 1'b1 : STATE_W'($urandom_range(0, 15));
      return load_word(IDX_W'($urandom_range(0, 15)), f, sym, t);
    end
    if ($urandom_range(0, 1) == 0) begin
      s = SET_W'(1) << $urandom_range(0, 15);
    end else begin
      s = SET_W'($urandom_range(0, 65535));
    end
    return query_word(s, SYM_W'($urandom_range(0, 3)));
  endfunction

  // Present one word and hold it until taken
  task automatic send_word(word_t w);
    while (!calm_run && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= w.cmd;
    entry_index_i  <= w.slot;
    entry_from_i   <= w.from_state;
    entry_symbol_i <= w.symbol;
    entry_to_i     <= w.to_state;
    query_set_i    <= w.qset;
    query_symbol_i <= w.qsym;
    do @(posedge clk_i); while (in_stall_o);
    board.note_word(w);
  endtask

  // Drain all replies, then write the active entry count
  task automatic set_active_entries(logic [ACT_W-1:0] v);
    in_valid_i <= 1'b0;
    while (board.pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_active(v);
  endtask

  initial begin
    logic [ACT_W-1:0] settings [8];
    settings = '{5'd31, 5'd5, 5'd16, 5'd0, 5'd1, 5'd17, 5'd12, 5'd9};
    settings[7] = ACT_W'($urandom_range(0, 31));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No active entries: a move finds nothing, a closure returns the set
    set_active_entries(5'd0);
    send_word(query_word(16'hFFFF, SYM_ZERO));
    send_word(query_word(16'hA5A5, SYM_EPS));

    // Fill every slot before any becomes active: epsilon cycles, a self
    // loop, a long epsilon ring and an entry with symbol three
    send_word(load_word(4'd0,  4'd0,  SYM_ZERO, 4'd1));
    send_word(load_word(4'd1,  4'd1,  SYM_EPS,  4'd2));
    send_word(load_word(4'd2,  4'd2,  SYM_EPS,  4'd3));
    send_word(load_word(4'd3,  4'd3,  SYM_EPS,  4'd1));
    send_word(load_word(4'd4,  4'd0,  SYM_ONE,  4'd4));
    send_word(load_word(4'd5,  4'd4,  SYM_EPS,  4'd4));
    send_word(load_word(4'd6,  4'd4,  SYM_EPS,  4'd15));
    send_word(load_word(4'd7,  4'd15, SYM_ONE,  4'd0));
    send_word(load_word(4'd8,  4'd15, 2'd3,     4'd7));
    send_word(load_word(4'd9,  4'd5,  SYM_EPS,  4'd6));
    send_word(load_word(4'd10, 4'd6,  SYM_EPS,  4'd7));
    send_word(load_word(4'd11, 4'd7,  SYM_EPS,  4'd8));
    send_word(load_word(4'd12, 4'd8,  SYM_EPS,  4'd9));
    send_word(load_word(4'd13, 4'd9,  SYM_EPS,  4'd10));
    send_word(load_word(4'd14, 4'd10, SYM_EPS,  4'd11));
    send_word(load_word(4'd15, 4'd11, SYM_EPS,  4'd5));

    set_active_entries(5'd16);
    send_word(query_word(16'h0001, SYM_ZERO));
    send_word(query_word(16'h0001, SYM_ONE));
    send_word(query_word(16'h0002, SYM_EPS));
    send_word(query_word(16'h8000, 2'd3));
    send_word(query_word(16'hFFFF, SYM_EPS));
    send_word(query_word(16'h0000, SYM_ZERO));
    send_word(query_word(16'h0020, SYM_EPS));

    // Random phases over several active counts; one phase runs without gaps
    for (int p = 0; p < 8; p++) begin
      set_active_entries(settings[p]);
      calm_run = (p == 2);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(random_word());
      end
      calm_run = 1'b0;
    end
    in_valid_i <= 1'b0;

    while (board.pending_replies.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.fault_count == 0 && board.pending_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
